### rtl/cdes_pkg.sv
// Package for the calendar date to epoch seconds converter.
// Holds the stream layout, status codes, arithmetic constants and month tables.
// No dependencies.
`default_nettype none

package cdes_pkg;

    // request layout on s_tdata, lowest bit first
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned OFFSET_W = 18;

    localparam int unsigned YEAR_LSB   = 0;
    localparam int unsigned MONTH_LSB  = YEAR_LSB + YEAR_W;
    localparam int unsigned DAY_LSB    = MONTH_LSB + MONTH_W;
    localparam int unsigned HOUR_LSB   = DAY_LSB + DAY_W;
    localparam int unsigned MINUTE_LSB = HOUR_LSB + HOUR_W;
    localparam int unsigned SECOND_LSB = MINUTE_LSB + MINUTE_W;
    localparam int unsigned OFFSET_LSB = SECOND_LSB + SECOND_W;
    localparam int unsigned IN_W       = 64;

    // result layout on m_tdata
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OUT_W    = 40;

    // internal widths
    localparam int unsigned QUOT_W  = 8;   // year / 100
    localparam int unsigned PROD_W  = 27;  // year * reciprocal
    localparam int unsigned LEAPS_W = 12;
    localparam int unsigned CUM_W   = 9;
    localparam int unsigned DAYS_W  = 23;
    localparam int unsigned TOD_W   = 19;  // signed time of day plus offset
    localparam int unsigned SECS_W  = 40;  // days * 86400
    localparam int unsigned TOTAL_W = 41;  // signed sum

    // constants
    localparam logic [YEAR_W-1:0]   EPOCH_YEAR      = 14'd1970;
    localparam logic [PROD_W-1:0]   DIV100_MULT     = 27'd5243;
    localparam int unsigned         DIV100_SHIFT    = 19;
    localparam logic [LEAPS_W-1:0]  LEAPS_TO_EPOCH  = 12'd477;
    localparam logic [DAYS_W-1:0]   DAYS_PER_YEAR   = 23'd365;
    localparam logic [SECS_W-1:0]   SECS_PER_DAY    = 40'd86400;
    localparam logic [TOD_W-1:0]    SECS_PER_HOUR   = 19'd3600;
    localparam logic [TOD_W-1:0]    SECS_PER_MINUTE = 19'd60;
    localparam logic [MONTH_W-1:0]  MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_DEC       = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_END_OF_DAY = 5'd24;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX      = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX      = 6'd59;
    localparam logic [DAY_W-1:0]    FEB_LEAP_DAYS   = 5'd29;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EARLY_YEAR = 2'd1,
        STATUS_BAD_FIELD  = 2'd2,
        STATUS_RANGE      = 2'd3
    } status_t;

    // length of a month in a common year
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in a common year before the first of the month
    function automatic logic [CUM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [CUM_W-1:0] cum;
        case (month)
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

### rtl/calendar_date_to_epoch_seconds.sv
// Calendar date and time to epoch seconds: five-stage pipelined converter.
// Depends on cdes_pkg for stream layout, status codes and month tables.
//
// Usage:
//   Requests arrive on the s_ stream (tvalid/tready/tdata) carrying year,
//   month, day, hour, minute, second and a signed offset in seconds. Each
//   request gives exactly one result on the m_ stream: the seconds since
//   1970-01-01 00:00:00 plus the offset, and a status (0 ok, 1 year before
//   1970, 2 bad date or time field, 3 result out of range). Seconds read all
//   ones whenever status is not ok.
//   One request can be taken every cycle while results are taken on the m_
//   stream. The stages are: field capture with the divide-by-100 multiply,
//   leap and month tables, day sum, the days * 86400 multiply, and the final
//   add with range check into the output register.
//   Each stage holds its own valid bit and moves on when the next stage is
//   empty or moving, so a stalled receiver fills the pipeline before
//   s_tready drops, and no request is lost or repeated.
//   Reset empties every stage; nothing else needs clearing.
`default_nettype none

module calendar_date_to_epoch_seconds (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output      logic                     s_tready,
    // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
    // second[39:34], offset_seconds[57:40], zero[63:58]
    input  wire logic [cdes_pkg::IN_W-1:0]  s_tdata,
    output      logic                     m_tvalid,
    input  wire logic                     m_tready,
    // epoch_seconds[31:0], status[33:32], zero[39:34]
    output      logic [cdes_pkg::OUT_W-1:0] m_tdata
);
    import cdes_pkg::*;

    // stage valid bits and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

    // stage 1 registers
    logic [YEAR_W-1:0]          s1_year_reg,   s1_year_next;
    logic [MONTH_W-1:0]         s1_month_reg,  s1_month_next;
    logic [DAY_W-1:0]           s1_day_reg,    s1_day_next;
    logic [HOUR_W-1:0]          s1_hour_reg,   s1_hour_next;
    logic [MINUTE_W-1:0]        s1_minute_reg, s1_minute_next;
    logic [SECOND_W-1:0]        s1_second_reg, s1_second_next;
    logic signed [OFFSET_W-1:0] s1_offset_reg, s1_offset_next;
    logic [QUOT_W-1:0]          s1_quot_reg,   s1_quot_next;
    status_t                    s1_status_reg, s1_status_next;

    // stage 2 registers
    logic [DAYS_W-1:0]          s2_ydays_reg,  s2_ydays_next;
    logic [LEAPS_W-1:0]         s2_leaps_reg,  s2_leaps_next;
    logic [CUM_W-1:0]           s2_cum_reg,    s2_cum_next;
    logic [DAY_W-1:0]           s2_day_reg,    s2_day_next;
    logic signed [TOD_W-1:0]    s2_tod_reg,    s2_tod_next;
    status_t                    s2_status_reg, s2_status_next;

    // stage 3 registers
    logic [DAYS_W-1:0]          s3_days_reg,   s3_days_next;
    logic signed [TOD_W-1:0]    s3_tod_reg;
    status_t                    s3_status_reg;

    // stage 4 registers
    logic [SECS_W-1:0]          s4_secs_reg,   s4_secs_next;
    logic signed [TOD_W-1:0]    s4_tod_reg;
    status_t                    s4_status_reg;

    // output registers
    logic [EPOCH_W-1:0]         out_epoch_reg,  out_epoch_next;
    status_t                    out_status_reg, out_status_next;

    // intermediate terms
    logic [PROD_W-1:0]          s1_prod;
    logic                       s1_bad;
    logic [YEAR_W-1:0]          s2_hundreds;
    logic                       s2_century;
    logic                       s2_leap;
    logic [QUOT_W-1:0]          s2_quot_m1;
    logic [YEAR_W-1:0]          s2_year_m1;
    logic [DAY_W-1:0]           s2_limit;
    logic signed [TOTAL_W-1:0]  s5_total;

    // back-pressure chain, each stage moves when the next one can take it
    assign out_ready = !out_valid_reg || m_tready;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    // stage 1: unpack, year / 100 by reciprocal, early field checks
    always_comb
    begin
        s1_year_next   = s_tdata[YEAR_LSB   +: YEAR_W];
        s1_month_next  = s_tdata[MONTH_LSB  +: MONTH_W];
        s1_day_next    = s_tdata[DAY_LSB    +: DAY_W];
        s1_hour_next   = s_tdata[HOUR_LSB   +: HOUR_W];
        s1_minute_next = s_tdata[MINUTE_LSB +: MINUTE_W];
        s1_second_next = s_tdata[SECOND_LSB +: SECOND_W];
        s1_offset_next = s_tdata[OFFSET_LSB +: OFFSET_W];

        s1_prod      = PROD_W'(s1_year_next) * DIV100_MULT;
        s1_quot_next = s1_prod[DIV100_SHIFT +: QUOT_W];

        s1_bad = (s1_month_next == '0) || (s1_month_next > MONTH_DEC)
              || (s1_day_next == '0)
              || (s1_hour_next == HOUR_END_OF_DAY
                  && (s1_minute_next != '0 || s1_second_next != '0))
              || (s1_hour_next > HOUR_END_OF_DAY)
              || (s1_minute_next > MINUTE_MAX) || (s1_second_next > SECOND_MAX);

        if (s1_year_next < EPOCH_YEAR)
            s1_status_next = STATUS_EARLY_YEAR;
        else if (s1_bad)
            s1_status_next = STATUS_BAD_FIELD;
        else
            s1_status_next = STATUS_OK;
    end

    // stage 2: leap rule, leap days since epoch, month tables, time of day
    always_comb
    begin
        s2_hundreds = YEAR_W'(s1_quot_reg) * YEAR_W'(100);
        s2_century  = (s2_hundreds == s1_year_reg);
        s2_leap     = (s1_year_reg[1:0] == 2'b00)
                   && (!s2_century || s1_quot_reg[1:0] == 2'b00);

        // leap years in 1..year-1, less those before the epoch
        s2_year_m1    = s1_year_reg - YEAR_W'(1);
        s2_quot_m1    = s1_quot_reg - QUOT_W'(s2_century);
        s2_leaps_next = LEAPS_W'(s2_year_m1 >> 2) - LEAPS_W'(s2_quot_m1)
                      + LEAPS_W'(s2_quot_m1 >> 2) - LEAPS_TO_EPOCH;

        s2_ydays_next = DAYS_W'(s1_year_reg - EPOCH_YEAR) * DAYS_PER_YEAR;
        s2_cum_next   = days_before_month(s1_month_reg)
                      + CUM_W'(s2_leap && (s1_month_reg > MONTH_FEB));
        s2_day_next   = s1_day_reg;

        s2_tod_next = TOD_W'(s1_hour_reg) * SECS_PER_HOUR
                    + TOD_W'(s1_minute_reg) * SECS_PER_MINUTE
                    + TOD_W'(s1_second_reg)
                    + TOD_W'(s1_offset_reg);

        // day against the month length, february longer in leap years
        if (s1_month_reg == MONTH_FEB && s2_leap)
            s2_limit = FEB_LEAP_DAYS;
        else
            s2_limit = month_days(s1_month_reg);

        if (s1_status_reg == STATUS_OK && s1_day_reg > s2_limit)
            s2_status_next = STATUS_BAD_FIELD;
        else
            s2_status_next = s1_status_reg;
    end

    // stage 3: whole days since epoch
    always_comb
    begin
        s3_days_next = s2_ydays_reg + DAYS_W'(s2_leaps_reg) + DAYS_W'(s2_cum_reg)
                     + DAYS_W'(s2_day_reg) - DAYS_W'(1);
    end

    // stage 4: days to seconds
    always_comb
    begin
        s4_secs_next = SECS_W'(s3_days_reg) * SECS_PER_DAY;
    end

    // stage 5: add time of day and offset, range check
    always_comb
    begin
        s5_total = $signed({1'b0, s4_secs_reg}) + TOTAL_W'(s4_tod_reg);
        if (s4_status_reg != STATUS_OK)
        begin
            out_status_next = s4_status_reg;
            out_epoch_next  = '1;
        end
        else if (s5_total[TOTAL_W-1:EPOCH_W] != '0)
        begin
            out_status_next = STATUS_RANGE;
            out_epoch_next  = '1;
        end
        else
        begin
            out_status_next = STATUS_OK;
            out_epoch_next  = s5_total[EPOCH_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (out_ready)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_year_reg   <= s1_year_next;
            s1_month_reg  <= s1_month_next;
            s1_day_reg    <= s1_day_next;
            s1_hour_reg   <= s1_hour_next;
            s1_minute_reg <= s1_minute_next;
            s1_second_reg <= s1_second_next;
            s1_offset_reg <= s1_offset_next;
            s1_quot_reg   <= s1_quot_next;
            s1_status_reg <= s1_status_next;
        end
        if (s2_ready)
        begin
            s2_ydays_reg  <= s2_ydays_next;
            s2_leaps_reg  <= s2_leaps_next;
            s2_cum_reg    <= s2_cum_next;
            s2_day_reg    <= s2_day_next;
            s2_tod_reg    <= s2_tod_next;
            s2_status_reg <= s2_status_next;
        end
        if (s3_ready)
        begin
            s3_days_reg   <= s3_days_next;
            s3_tod_reg    <= s2_tod_reg;
            s3_status_reg <= s2_status_reg;
        end
        if (s4_ready)
        begin
            s4_secs_reg   <= s4_secs_next;
            s4_tod_reg    <= s3_tod_reg;
            s4_status_reg <= s3_status_reg;
        end
        if (out_ready)
        begin
            out_epoch_reg  <= out_epoch_next;
            out_status_reg <= out_status_next;
        end
    end

    // result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - EPOCH_W - STATUS_W){1'b0}}, out_status_reg, out_epoch_reg};

endmodule

`default_nettype wire
